// ----- rtl/midi_message_assembler_macros.svh -----
// assertion macros for the midi message assembler
// included by the rtl files that carry concurrent assertions
`ifndef MIDI_MESSAGE_ASSEMBLER_MACROS_SVH
`define MIDI_MESSAGE_ASSEMBLER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define MMA_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("midi message assembler assertion failed");
// next-cycle implication, disabled while in reset
`define MMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("midi message assembler assertion failed");
`else
`define MMA_ASSERT(lbl, clk, rst_n, ante, cons)
`define MMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/mma_pkg.sv -----
// shared types, constants and the status decode for the midi message assembler
// no dependencies
package mma_pkg;

  typedef enum logic {
    KIND_MESSAGE = 1'b0,
    KIND_ERROR   = 1'b1
  } result_kind_e;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'ha;
  localparam logic [3:0] HI_CONTROL   = 4'hb;
  localparam logic [3:0] HI_PROGRAM   = 4'hc;
  localparam logic [3:0] HI_CHAN_AT   = 4'hd;
  localparam logic [3:0] HI_PITCH     = 4'he;
  localparam logic [3:0] HI_SYSTEM    = 4'hf;
  localparam logic [7:0] ST_TIME_CODE = 8'hf1;
  localparam logic [7:0] ST_SONG_POS  = 8'hf2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hf3;
  localparam logic [7:0] NO_STATUS    = 8'h00;

  // byte register between the input stage and the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] midi_byte;
  } byte_stage_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   status_value;
    logic [6:0]   first_data;
    logic [6:0]   second_data;
    logic [1:0]   data_count;
  } msg_t;

  // data bytes a status byte calls for
  function automatic logic [1:0] data_needed(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s[7]) begin
      unique case (s[7:4])
        HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL, HI_PITCH: n = 2'd2;
        HI_PROGRAM, HI_CHAN_AT: n = 2'd1;
        HI_SYSTEM: begin
          if (s == ST_TIME_CODE || s == ST_SONG_SEL) n = 2'd1;
          else if (s == ST_SONG_POS) n = 2'd2;
          else n = 2'd0;
        end
        default: n = 2'd0;
      endcase
    end
    return n;
  endfunction

endpackage

// ----- rtl/mma_if.sv -----
// valid/ready channel interfaces: raw midi bytes in, assembled messages out
// no dependencies
interface mma_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

interface mma_msg_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] status_value;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic [1:0] data_count;

  modport source (output valid, output result_kind, output status_value,
                  output first_data, output second_data, output data_count,
                  input ready);
  modport sink (input valid, input result_kind, input status_value,
                input first_data, input second_data, input data_count,
                output ready);
endinterface

// ----- rtl/midi_message_assembler.sv -----
// midi message assembler: groups raw midi bytes into complete messages
// with running status
//   byte_i : sink channel, one raw byte per transaction (bit 7 set = status)
//   msg_o  : source channel, one assembled message or an error per result
// a status byte that needs no data is sent on at once; channel and system
// common messages go out when their last data byte arrives. data with no
// status yet gives an error result and is dropped.
// the byte that completes a result is held in the input register, and the
// parser loads the result register when it takes that byte from there;
// msg_o.valid is driven from the result register.
// throughput: one byte per cycle while msg_o does not stall; the decode and
// counter update sit in a single stage between the input and result registers.
// a stall on msg_o holds the result register; the input register, if empty,
// still takes one more byte, then byte_i.ready drops until the result is taken.
// reset clears the held status, the counts and both valid flags.
// depends on mma_pkg, mma_if, mma_in_stage and mma_parser
module midi_message_assembler
  import mma_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mma_byte_if.sink   byte_i,
  mma_msg_if.source  msg_o
);

  byte_stage_t stage;
  logic        take;

  mma_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .stage_o (stage)
  );

  mma_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_o  (take),
    .msg_o   (msg_o)
  );

endmodule

// ----- rtl/mma_in_stage.sv -----
// input register for the midi byte channel
// depends on mma_pkg and mma_if
module mma_in_stage
  import mma_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  mma_byte_if.sink     byte_i,
  input  logic         take_i,
  output byte_stage_t  stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // accept whenever empty or the held byte leaves this cycle
  assign byte_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (byte_i.ready) valid_d = byte_i.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) byte_q <= byte_i.midi_byte;
  end

  assign stage_o.valid     = valid_q;
  assign stage_o.midi_byte = byte_q;

endmodule

// ----- rtl/mma_parser.sv -----
// running status parser with its result register
// depends on mma_pkg, mma_if and midi_message_assembler_macros.svh
`include "midi_message_assembler_macros.svh"
module mma_parser
  import mma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  byte_stage_t stage_i,
  output logic        take_o,
  mma_msg_if.source   msg_o
);

  logic [7:0] held_q, held_d;
  logic [1:0] need_q, need_d;
  logic [1:0] rcv_q, rcv_d;
  logic [6:0] first_q, first_d;
  logic [6:0] second_q, second_d;
  logic       out_valid_q, out_valid_d;
  msg_t       out_q, res;
  logic       res_valid;
  logic       out_space;
  logic [1:0] rcv_inc;

  assign out_space = !out_valid_q || msg_o.ready;
  assign take_o    = stage_i.valid && out_space;
  assign rcv_inc   = (rcv_q == 2'd3) ? 2'd3 : rcv_q + 2'd1;

  always_comb begin
    held_d    = held_q;
    need_d    = need_q;
    rcv_d     = rcv_q;
    first_d   = first_q;
    second_d  = second_q;
    res_valid = 1'b0;
    res       = '{kind: KIND_MESSAGE, status_value: 8'h00, first_data: 7'h00,
                  second_data: 7'h00, data_count: 2'd0};
    if (take_o) begin
      if (stage_i.midi_byte[7]) begin
        held_d = stage_i.midi_byte;
        need_d = data_needed(stage_i.midi_byte);
        rcv_d  = 2'd0;
        if (need_d == 2'd0) begin
          res_valid        = 1'b1;
          res.status_value = stage_i.midi_byte;
        end
      end else if (held_q == NO_STATUS) begin
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
      end else begin
        if (rcv_q == 2'd0) first_d = stage_i.midi_byte[6:0];
        else if (rcv_q == 2'd1) second_d = stage_i.midi_byte[6:0];
        rcv_d = rcv_inc;
        // zero-data status never matches, so extra bytes just saturate
        if (rcv_inc == need_q) begin
          res_valid        = 1'b1;
          res.status_value = held_q;
          res.first_data   = (need_q >= 2'd1) ? first_d : 7'h00;
          res.second_data  = (need_q >= 2'd2) ? second_d : 7'h00;
          res.data_count   = need_q;
          rcv_d            = 2'd0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_space) out_valid_d = take_o && res_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= NO_STATUS;
      need_q      <= 2'd0;
      rcv_q       <= 2'd0;
      first_q     <= 7'h00;
      second_q    <= 7'h00;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      need_q      <= need_d;
      rcv_q       <= rcv_d;
      first_q     <= first_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid) out_q <= res;
  end

  assign msg_o.valid        = out_valid_q;
  assign msg_o.result_kind  = out_q.kind;
  assign msg_o.status_value = out_q.status_value;
  assign msg_o.first_data   = out_q.first_data;
  assign msg_o.second_data  = out_q.second_data;
  assign msg_o.data_count   = out_q.data_count;

  `MMA_ASSERT(a_error_fields_zero, clk_i, rst_ni, out_valid_q && out_q.kind == KIND_ERROR, out_q.status_value == 8'h00 && out_q.data_count == 2'd0 && out_q.first_data == 7'h00)
  `MMA_ASSERT(a_message_has_status, clk_i, rst_ni, out_valid_q && out_q.kind == KIND_MESSAGE, out_q.status_value[7])
  `MMA_ASSERT(a_partial_below_need, clk_i, rst_ni, held_q != NO_STATUS && need_q != 2'd0, rcv_q < need_q)
  `MMA_ASSERT(a_idle_counts_clear, clk_i, rst_ni, held_q == NO_STATUS, rcv_q == 2'd0 && need_q == 2'd0)
  `MMA_ASSERT_NEXT(a_orphan_data_error, clk_i, rst_ni, take_o && !stage_i.midi_byte[7] && held_q == NO_STATUS, out_valid_q && out_q.kind == KIND_ERROR)

endmodule

// ----- bench/midi_message_assembler_checker.sv -----
// checker for the midi message assembler: watches both channels, predicts
// every assembled message and compares it field by field
// depends on mma_pkg
`timescale 1ns / 100ps

module midi_message_assembler_checker
  import mma_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic       byte_ready_i,
  input  logic [7:0] midi_byte_i,
  input  logic       msg_valid_i,
  input  logic       msg_ready_i,
  input  logic       result_kind_i,
  input  logic [7:0] status_value_i,
  input  logic [6:0] first_data_i,
  input  logic [6:0] second_data_i,
  input  logic [1:0] data_count_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         msg_count_o,
  output int         err_count_o
);

  // running status as the block should hold it
  logic [7:0] run_status;
  logic [1:0] need_cnt;
  logic [1:0] got_cnt;
  logic [6:0] first_b;
  logic [6:0] second_b;

  msg_t expected_msgs [$];

  function automatic logic [1:0] bytes_for_status(input logic [7:0] st);
    logic [3:0] hi;
    hi = st[7:4];
    if (!st[7]) return 2'd0;
    if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON || hi == HI_POLY_AT ||
        hi == HI_CONTROL || hi == HI_PITCH || st == ST_SONG_POS) return 2'd2;
    if (hi == HI_PROGRAM || hi == HI_CHAN_AT || st == ST_TIME_CODE ||
        st == ST_SONG_SEL) return 2'd1;
    return 2'd0;
  endfunction

  task automatic assemble_byte(input logic [7:0] b);
    msg_t m;
    m = '0;
    m.kind = KIND_MESSAGE;
    if (b[7]) begin
      // a new status drops any partial message
      run_status = b;
      need_cnt = bytes_for_status(b);
      got_cnt = 2'd0;
      if (need_cnt == 2'd0) begin
        m.status_value = b;
        expected_msgs.push_back(m);
      end
    end else if (run_status == NO_STATUS) begin
      m.kind = KIND_ERROR;
      expected_msgs.push_back(m);
    end else begin
      if (got_cnt == 2'd0) first_b = b[6:0];
      else if (got_cnt == 2'd1) second_b = b[6:0];
      if (got_cnt != 2'd3) got_cnt = got_cnt + 2'd1;
      if (got_cnt == need_cnt) begin
        m.status_value = run_status;
        m.first_data = (need_cnt >= 2'd1) ? first_b : 7'd0;
        m.second_data = (need_cnt >= 2'd2) ? second_b : 7'd0;
        m.data_count = need_cnt;
        expected_msgs.push_back(m);
        got_cnt = 2'd0;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: msg_o %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic compare_result();
    msg_t want;
    if (expected_msgs.size() == 0) begin
      $display("%0t: unexpected transaction on msg_o: kind %0d status %02h data %02h %02h count %0d",
               $time, result_kind_i, status_value_i, first_data_i, second_data_i,
               data_count_i);
      fail_count_o++;
    end else begin
      want = expected_msgs.pop_front();
      check_field("result_kind", want.kind, result_kind_i);
      check_field("status_value", want.status_value, status_value_i);
      check_field("first_data", want.first_data, first_data_i);
      check_field("second_data", want.second_data, second_data_i);
      check_field("data_count", want.data_count, data_count_i);
      if (want.kind == KIND_ERROR) err_count_o++;
      else msg_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status = NO_STATUS;
      need_cnt = 2'd0;
      got_cnt = 2'd0;
      first_b = 7'd0;
      second_b = 7'd0;
      expected_msgs.delete();
      fail_count_o = 0;
      msg_count_o = 0;
      err_count_o = 0;
    end else begin
      // results first, so a byte taken at the same edge cannot hide a stray one
      if (msg_valid_i && msg_ready_i) compare_result();
      if (byte_valid_i && byte_ready_i) assemble_byte(midi_byte_i);
    end
    pending_o = expected_msgs.size();
  end

endmodule

// ----- bench/midi_message_assembler_test.sv -----
// top of the midi message assembler bench: clock, reset, byte stimulus,
// randomly stalling message receiver and the verdict
// depends on mma_pkg, mma_if, midi_message_assembler and its checker
`timescale 1ns / 100ps

module midi_message_assembler_test;
  import mma_pkg::*;

  localparam int RANDOM_BYTES = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 250;
  localparam int DRAIN_CYCLES = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  mma_byte_if byte_ch ();
  mma_msg_if  msg_ch ();

  int fails;
  int pending;
  int msgs_seen;
  int errs_seen;
  int bytes_sent;
  int msgs_taken;
  int cycle_count;
  logic tx_burst;
  logic rx_burst;
  logic long_hold;

  logic [3:0] two_byte_hi [0:4] = '{HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL,
                                    HI_PITCH};

  // errors before any status, every data count, running status, an abandoned
  // partial message and data past a status that takes none
  logic [7:0] opening_bytes [0:24] = '{
    8'h00, 8'h7f,
    {HI_NOTE_OFF, 4'h0}, 8'h00, 8'h7f,
    {HI_NOTE_ON, 4'hf}, 8'h3c,
    {HI_PROGRAM, 4'h5}, 8'h7f, 8'h00,
    {HI_CHAN_AT, 4'ha}, 8'h01,
    ST_TIME_CODE, 8'h55,
    ST_SONG_POS, 8'h7f, 8'h00,
    ST_SONG_SEL, 8'h11,
    {HI_SYSTEM, 4'h8}, 8'h01, 8'h02, 8'h03, 8'h04,
    {HI_SYSTEM, 4'hf}
  };

  midi_message_assembler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .msg_o  (msg_ch)
  );

  midi_message_assembler_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (byte_ch.valid),
    .byte_ready_i   (byte_ch.ready),
    .midi_byte_i    (byte_ch.midi_byte),
    .msg_valid_i    (msg_ch.valid),
    .msg_ready_i    (msg_ch.ready),
    .result_kind_i  (msg_ch.result_kind),
    .status_value_i (msg_ch.status_value),
    .first_data_i   (msg_ch.first_data),
    .second_data_i  (msg_ch.second_data),
    .data_count_i   (msg_ch.data_count),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .msg_count_o    (msgs_seen),
    .err_count_o    (errs_seen)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d messages still expected", cycle_count, pending);
      $display("[midi_message_assembler] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] random_data();
    return {1'b0, 7'($urandom_range(0, 127))};
  endfunction

  function automatic logic [7:0] random_status(input int need);
    int sel;
    logic [3:0] lo;
    lo = 4'($urandom_range(0, 15));
    if (need == 2) begin
      sel = $urandom_range(0, 5);
      return (sel == 5) ? ST_SONG_POS : {two_byte_hi[sel], lo};
    end
    if (need == 1) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) return {HI_PROGRAM, lo};
      if (sel == 1) return {HI_CHAN_AT, lo};
      return (sel == 2) ? ST_TIME_CODE : ST_SONG_SEL;
    end
    // system bytes that take no data
    lo = 4'($urandom_range(3, 15));
    if (lo == 4'h3) lo = 4'h0;
    return {HI_SYSTEM, lo};
  endfunction

  // one transaction on byte_i; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (bytes_sent % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = (tx_burst || long_hold) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.midi_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // mostly well-formed messages under running status, some noise and
  // messages cut short by the next status
  task automatic send_phrase();
    int pick;
    int need;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    need = $urandom_range(0, 2);
    send_byte(random_status(need));
    if (need == 0) begin
      repeat ($urandom_range(0, 5)) send_byte(random_data());
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      repeat (need) send_byte(random_data());
    end
    if (pick < 20 && need == 2) send_byte(random_data());
  endtask

  // message receiver with random stalls and two long hold-offs
  initial begin
    int gap;
    msg_ch.ready = 1'b0;
    msgs_taken = 0;
    long_hold = 1'b0;
    rx_burst = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (msgs_taken % 30 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (msgs_taken == 60 || msgs_taken == 300) begin
        // hold off while the sender streams, so the block backs up
        long_hold <= 1'b1;
        msg_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold <= 1'b0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        msg_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      msg_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!msg_ch.valid) @(posedge clk_i);
      msgs_taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    cycle_count = 0;
    bytes_sent = 0;
    tx_burst = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.midi_byte = 8'h00;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    while (bytes_sent < RANDOM_BYTES + 25) send_phrase();
    byte_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d midi bytes in %0d cycles under random stalls on both channels",
             bytes_sent, cycle_count);
    $display("compared %0d assembled messages and %0d no-status errors", msgs_seen,
             errs_seen);
    if (fails == 0) begin
      $display("[midi_message_assembler] OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("[midi_message_assembler] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mma_pkg.sv
rtl/mma_if.sv
rtl/mma_in_stage.sv
rtl/mma_parser.sv
rtl/midi_message_assembler.sv
bench/midi_message_assembler_checker.sv
bench/midi_message_assembler_test.sv
